// File: design/cbd_pkg.sv
`default_nettype none

package cbd_pkg;

   // Memory sizes and address widths
   localparam int RAM_DEPTH = 2048;
   localparam int ROM_DEPTH = 32768;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam int ROM_AW    = $clog2(ROM_DEPTH);

   // Access kinds carried in the request
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_LOAD  = 2'd2;

   // Where the read data of an access comes from
   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_RAM  = 2'd1;
   localparam logic [1:0] SRC_ROM  = 2'd2;

   // Fixed bus addresses
   localparam logic [15:0] DMA_ADDR = 16'h4014;

   // PPU register numbers of interest
   localparam logic [2:0] PPU_STATUS = 3'd2;
   localparam logic [2:0] PPU_OAMDATA = 3'd4;
   localparam logic [2:0] PPU_DATA = 3'd7;

   // Decoded access, everything except the memory read data
   typedef struct packed {
      logic [1:0] src;
      logic       ppu_strobe;
      logic       ppu_is_write;
      logic [2:0] ppu_reg;
      logic [7:0] ppu_wdata;
      logic       dma_start;
      logic [7:0] dma_page;
      logic       bad_write;
   } info_type;

   // Request to the memories for one access
   typedef struct packed {
      logic              rd_en;
      logic              ram_we;
      logic              rom_we;
      logic [RAM_AW-1:0] ram_addr;
      logic [ROM_AW-1:0] rom_raddr;
      logic [ROM_AW-1:0] rom_waddr;
      logic [7:0]        wdata;
   } mem_req_type;

endpackage

`default_nettype wire

// File: design/cbd_decode.sv
`default_nettype none

module cbd_decode
   import cbd_pkg::*;
(
   input  wire logic        accept,
   input  wire logic        rom_is_16k,
   input  wire logic [1:0]  mode,
   input  wire logic [15:0] addr,
   input  wire logic [7:0]  wdata,
   input  wire logic [14:0] rom_offset,
   output info_type         info,
   output mem_req_type      mem_req
);

   logic in_ram;
   logic in_ppu;
   logic in_rom;

   // Address regions
   assign in_ram = (addr[15:13] == 3'b000);
   assign in_ppu = (addr[15:13] == 3'b001);
   assign in_rom = addr[15];

   // Memory side: addresses are always formed, enables only on an accepted request
   always_comb begin
      mem_req.rd_en     = accept;
      mem_req.ram_we    = accept && (mode == MODE_WRITE) && in_ram;
      mem_req.rom_we    = accept && (mode == MODE_LOAD);
      mem_req.ram_addr  = addr[RAM_AW-1:0];
      mem_req.rom_raddr = {addr[14] & ~rom_is_16k, addr[13:0]};
      mem_req.rom_waddr = rom_offset[ROM_AW-1:0];
      mem_req.wdata     = wdata;
   end

   // Register side effects of the access
   always_comb begin
      info = '0;
      case (mode)
         MODE_READ: begin
            if (in_ram) begin
               info.src = SRC_RAM;
            end else if (in_ppu) begin
               if (addr[2:0] inside {PPU_STATUS, PPU_OAMDATA, PPU_DATA}) begin
                  info.ppu_strobe = 1'b1;
                  info.ppu_reg    = addr[2:0];
               end
            end else if (in_rom) begin
               info.src = SRC_ROM;
            end
         end
         MODE_WRITE: begin
            if (in_ppu) begin
               // The status register is read only
               if (addr[2:0] == PPU_STATUS) begin
                  info.bad_write = 1'b1;
               end else begin
                  info.ppu_strobe   = 1'b1;
                  info.ppu_is_write = 1'b1;
                  info.ppu_reg      = addr[2:0];
                  info.ppu_wdata    = wdata;
               end
            end else if (addr == DMA_ADDR) begin
               info.dma_start = 1'b1;
               info.dma_page  = wdata;
            end else if (in_rom) begin
               info.bad_write = 1'b1;
            end
         end
         default: begin
            info = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/cbd_mem.sv
`default_nettype none

module cbd_mem
   import cbd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire mem_req_type mem_req,
   output logic [7:0] ram_rdata,
   output logic [7:0] rom_rdata,
   output logic       clearing
);

   logic [7:0] ram [RAM_DEPTH];
   logic [7:0] rom [ROM_DEPTH];

   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [RAM_AW-1:0] clr_addr_ff;
   logic [RAM_AW-1:0] clr_addr_in;
   logic [7:0]        ram_rdata_ff;
   logic [7:0]        rom_rdata_ff;

   // Clearing sweep over the work RAM after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Work RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         ram[clr_addr_ff] <= 8'h00;
      end else if (mem_req.ram_we) begin
         ram[mem_req.ram_addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         ram_rdata_ff <= ram[mem_req.ram_addr];
      end
   end

   // Program ROM: loaded through the bus, registered read port
   always_ff @(posedge clock) begin
      if (mem_req.rom_we) begin
         rom[mem_req.rom_waddr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rom_rdata_ff <= rom[mem_req.rom_raddr];
      end
   end

   assign ram_rdata = ram_rdata_ff;
   assign rom_rdata = rom_rdata_ff;
   assign clearing  = clr_busy_ff;

endmodule

`default_nettype wire

// File: design/console_cpu_bus_decoder.sv
`default_nettype none

// CPU bus decoder for the console memory map. Each request is one bus access (read, write
// or program ROM byte load) and gives exactly one response. One request is taken every
// clock cycle while the response channel is not back-pressured; each request passes the
// first stage, beside the registered read of the work RAM and program ROM, and then the
// output register. After reset the 2 KB work RAM is cleared by a sweep over all 2048
// addresses, during which no request is taken; the ROM size register may be written at
// any time the bus is idle, including during that sweep.
module console_cpu_bus_decoder
   import cbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: addr[15:0], wdata[23:16], rom_offset[38:24], zero fill[39]
   input  wire logic [39:0] req_tdata,
   // tuser: mode[1:0]
   input  wire logic [1:0]  req_tuser,
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: rd_byte[7:0], ppu_strobe[8], ppu_is_write[9], ppu_reg[12:10],
   //        ppu_wdata[20:13], dma_start[21], dma_page[29:22], bad_write[30], zero[31]
   output logic [31:0]      rsp_tdata,
   // ROM size register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data
);

   logic        rom16_ff;
   logic        clearing;
   logic        accept;
   logic        out_free;
   logic        s1_adv;
   info_type    dec_info;
   mem_req_type mem_req;
   logic [7:0]  ram_rdata;
   logic [7:0]  rom_rdata;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   info_type    s1_info_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   info_type    out_info_ff;
   logic [7:0]  out_rdata_ff;
   logic [7:0]  out_rdata_in;

   // ROM size register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rom16_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         rom16_ff <= csr_data;
      end
   end

   // Handshake and pipeline advance
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !clearing && (!s1_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   cbd_decode u_decode (
      .accept     (accept),
      .rom_is_16k (rom16_ff),
      .mode       (req_tuser),
      .addr       (req_tdata[15:0]),
      .wdata      (req_tdata[23:16]),
      .rom_offset (req_tdata[38:24]),
      .info       (dec_info),
      .mem_req    (mem_req)
   );

   cbd_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (mem_req),
      .ram_rdata (ram_rdata),
      .rom_rdata (rom_rdata),
      .clearing  (clearing)
   );

   // First stage: decoded request alongside the memory read
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= dec_info;
      end
   end

   // Select the read data by its source
   always_comb begin
      case (s1_info_ff.src)
         SRC_RAM: out_rdata_in = ram_rdata;
         SRC_ROM: out_rdata_in = rom_rdata;
         default: out_rdata_in = 8'h00;
      endcase
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_info_ff  <= s1_info_ff;
         out_rdata_ff <= out_rdata_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_info_ff.bad_write, out_info_ff.dma_page,
                        out_info_ff.dma_start, out_info_ff.ppu_wdata, out_info_ff.ppu_reg,
                        out_info_ff.ppu_is_write, out_info_ff.ppu_strobe, out_rdata_ff};

   // No request is taken while the work RAM is being cleared.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("request taken during RAM clearing");

   // A taken request is held in the first stage on the next cycle.
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request lost");

   // A PPU strobe never comes with read data, DMA or an error.
   a_strobe_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_info_ff.ppu_strobe) |->
         (out_rdata_ff == 8'h00 && !out_info_ff.dma_start && !out_info_ff.bad_write))
      else $error("PPU strobe mixed with other effects");

   // Read data only ever comes from a RAM or ROM source.
   a_rdata_source: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (s1_info_ff.src == SRC_NONE) |=> (out_rdata_ff == 8'h00))
      else $error("read data without a memory source");

endmodule

`default_nettype wire
